[rtl/swvm_pkg.sv]
// Shared types and constants for the sliding-window vibration monitor.
package swvm_pkg;

  // Field widths fixed by the item and register formats.
  localparam int unsigned SampleW = 12;
  localparam int unsigned MinCntW = 4;
  localparam int unsigned HeldW   = 4;

  // Register reset values.
  localparam logic [SampleW-1:0] ThresholdRst = 12'd800;
  localparam logic [MinCntW-1:0] MinCountRst  = 4'd3;

  // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned RegSelBit = 2;

  // Register indexes, as decoded from the word-select address bit.
  localparam logic RegIdxThreshold = 1'b0;
  localparam logic RegIdxMinCount  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // capture the input sample
    logic fetch;   // read the entry at the write slot
    logic update;  // write the sample, update sum/fill/slot, start scan and divide
    logic run;     // advance the scan and the divider
    logic load;    // load the output registers
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
  } sts_t;

endpackage

[rtl/swvm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module swvm_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 10,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/swvm_datapath.sv]
// Datapath: sample store, running sum, window scan and bit-serial mean divider.
module swvm_datapath #(
  parameter int unsigned Window = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swvm_pkg::cmd_t                 cmd_i,
  output swvm_pkg::sts_t                 sts_o,
  input  logic [swvm_pkg::SampleW-1:0]   sample_i,
  input  logic [swvm_pkg::SampleW-1:0]   threshold_i,
  input  logic [swvm_pkg::MinCntW-1:0]   min_count_i,
  output logic [swvm_pkg::SampleW-1:0]   mean_o,
  output logic [swvm_pkg::SampleW-1:0]   peak_o,
  output logic                           danger_o,
  output logic [swvm_pkg::HeldW-1:0]     held_o
);

  localparam int unsigned SW    = swvm_pkg::SampleW;
  localparam int unsigned MW    = swvm_pkg::MinCntW;
  localparam int unsigned HW    = swvm_pkg::HeldW;
  localparam int unsigned SumW  = $clog2(Window * ((1 << SW) - 1) + 1);
  localparam int unsigned FillW = $clog2(Window + 1);
  localparam int unsigned IdxW  = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW  = $clog2(SumW + 1);

  logic [SW-1:0]    sample_q;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [FillW-1:0] idx_q;
  logic             pend_q;
  logic [SW-1:0]    peak_q;
  logic [FillW-1:0] crit_q;
  logic [SumW-1:0]  quo_q;
  logic [FillW-1:0] rem_q;
  logic [CntW-1:0]  div_cnt_q;
  logic [SW-1:0]    mean_q, peak_out_q;
  logic             danger_q;
  logic [HW-1:0]    held_q;

  logic             full;
  logic             scan_issue;
  logic [SW-1:0]    rdata;
  logic [SW-1:0]    old_sample;
  logic [IdxW-1:0]  raddr;
  logic [FillW:0]   trial, trial_diff;
  logic             trial_ge;
  logic [SumW+SW-1:0]  quo_ext;
  logic [FillW+HW-1:0] fill_ext;
  logic [FillW+MW-1:0] crit_ext, min_ext;

  // Window store.
  assign raddr = cmd_i.fetch ? slot_q : idx_q[IdxW-1:0];

  swvm_ram #(
    .Width (SW),
    .Depth (Window)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.fetch | scan_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Insert: the oldest sample leaves the sum once the window is full.
  always_comb begin
    full       = (fill_q == FillW'(Window));
    old_sample = full ? rdata : '0;
    sum_d      = (sum_q - SumW'(old_sample)) + SumW'(sample_q);
    fill_d     = full ? fill_q : fill_q + FillW'(1);
    slot_d     = (slot_q == IdxW'(Window - 1)) ? '0 : slot_q + IdxW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.update) begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  // Scan of the held entries: one read issued per cycle, each compared in the cycle after its issue.
  assign scan_issue = cmd_i.run && (idx_q < fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.update) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.run) begin
      if (scan_issue) begin
        idx_q <= idx_q + FillW'(1);
      end
      pend_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      peak_q <= '0;
      crit_q <= '0;
    end else if (cmd_i.run && pend_q) begin
      if (rdata > peak_q) begin
        peak_q <= rdata;
      end
      if (rdata > threshold_i) begin
        crit_q <= crit_q + FillW'(1);
      end
    end
  end

  // Restoring divider for the mean, one quotient bit per cycle.
  always_comb begin
    trial      = {rem_q, quo_q[SumW-1]};
    trial_diff = trial - {1'b0, fill_q};
    trial_ge   = (trial >= {1'b0, fill_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.update) begin
      div_cnt_q <= CntW'(SumW);
    end else if (cmd_i.run && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (cmd_i.run && (div_cnt_q != '0)) begin
      quo_q <= {quo_q[SumW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_diff[FillW-1:0] : trial[FillW-1:0];
    end
  end

  assign sts_o.scan_done = (idx_q >= fill_q) && !pend_q;
  assign sts_o.div_done  = (div_cnt_q == '0);

  // Output register.
  always_comb begin
    quo_ext  = {{SW{1'b0}}, quo_q};
    fill_ext = {{HW{1'b0}}, fill_q};
    crit_ext = {{MW{1'b0}}, crit_q};
    min_ext  = {{FillW{1'b0}}, min_count_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mean_q     <= quo_ext[SW-1:0];
      peak_out_q <= peak_q;
      danger_q   <= (crit_ext > min_ext);
      held_q     <= fill_ext[HW-1:0];
    end
  end

  assign mean_o   = mean_q;
  assign peak_o   = peak_out_q;
  assign danger_o = danger_q;
  assign held_o   = held_q;

endmodule

[rtl/swvm_ctrl.sv]
// Controller: sequences fetch, insert, scan/divide and result transfer per sample.
module swvm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output swvm_pkg::cmd_t cmd_o,
  input  swvm_pkg::sts_t sts_i
);

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StFetch   = 5'b00010,
    StUpdate  = 5'b00100,
    StRun     = 5'b01000,
    StDeliver = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next-state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        cmd_o.fetch = 1'b1;
        state_d     = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StRun;
      end
      StRun: begin
        cmd_o.run = 1'b1;
        if (sts_i.scan_done && sts_i.div_done) begin
          state_d = StDeliver;
        end
      end
      StDeliver: begin
        // Wait until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid flag: set on load, cleared when the result transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/sliding_window_vibration_monitor.sv]
// Top level of the sliding-window vibration monitor: registers, controller, datapath.
//
// Input channel: sample_i with in_valid_i/in_stall_o; a transfer happens at a
// clock edge with in_valid_i high and in_stall_o low. Each sample enters a ring
// of the last WINDOW samples, and one result per sample leaves on the output
// channel (mean_o, peak_o, danger_o, held_o with out_valid_o/out_stall_i).
// The block works on one sample at a time: after an input transfer it fetches
// the oldest entry, inserts the sample, runs the window scan and the bit-serial
// mean divider over the S-bit running sum (S = 16 bits at WINDOW = 10), with
// the scan reading one store entry per cycle, and then loads the result. The
// next sample can be taken in the cycle after the result is loaded. The output
// register holds a finished result while the receiver stalls; a new sample is
// still taken, and its result waits until the previous result transfers. Reset
// empties the window and restores the threshold (800) and min count (3). The
// user must write the registers over the APB-style port only while the block is
// idle; the block does not enforce this. Threshold is at address 0, min count at 4.
module sliding_window_vibration_monitor #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [swvm_pkg::SampleW-1:0]    sample_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output logic [swvm_pkg::SampleW-1:0]    mean_o,
  output logic [swvm_pkg::SampleW-1:0]    peak_o,
  output logic                            danger_o,
  output logic [swvm_pkg::HeldW-1:0]      held_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swvm_pkg::ApbAddrW-1:0]   paddr,
  input  logic [swvm_pkg::ApbDataW-1:0]   pwdata,
  output logic [swvm_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned SW = swvm_pkg::SampleW;
  localparam int unsigned MW = swvm_pkg::MinCntW;
  localparam int unsigned DW = swvm_pkg::ApbDataW;

  logic [SW-1:0]  threshold_q;
  logic [MW-1:0]  min_count_q;
  logic           reg_wr;
  logic           reg_sel;
  swvm_pkg::cmd_t cmd;
  swvm_pkg::sts_t sts;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[swvm_pkg::RegSelBit];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= swvm_pkg::ThresholdRst;
      min_count_q <= swvm_pkg::MinCountRst;
    end else if (reg_wr) begin
      if (reg_sel == swvm_pkg::RegIdxThreshold) begin
        threshold_q <= pwdata[SW-1:0];
      end else begin
        min_count_q <= pwdata[MW-1:0];
      end
    end
  end

  // Register read-back.
  assign prdata = (reg_sel == swvm_pkg::RegIdxMinCount) ? {{(DW - MW){1'b0}}, min_count_q}
                                                        : {{(DW - SW){1'b0}}, threshold_q};

  swvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  swvm_datapath #(
    .Window (WINDOW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (sample_i),
    .threshold_i (threshold_q),
    .min_count_i (min_count_q),
    .mean_o      (mean_o),
    .peak_o      (peak_o),
    .danger_o    (danger_o),
    .held_o      (held_o)
  );

endmodule
